/* sv/swmf_pkg.sv */
package swmf_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 5;
  localparam int FILL_W   = 5;

  // Default window capacity and reset window size
  localparam int             MAX_WINDOW_DEF = 16;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd5;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } swmf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic [FILL_W-1:0]          fill_count;
  } swmf_out_t;

  // Control broadcast to every cell of the sorted chain
  typedef struct packed {
    logic upd;   // insert a new sample this cycle
    logic clr;   // empty the chain
    logic full;  // window full: the oldest sample leaves
  } swmf_ctl_t;

endpackage

/* sv/swmf_cell.sv */
module swmf_cell import swmf_pkg::*; #(
  parameter int AW  = 4,
  parameter int SLW = 1 + AW + SAMPLE_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swmf_ctl_t                  ctl,
  input  logic [AW-1:0]              oldest_age,
  input  logic signed [SAMPLE_W-1:0] new_sample,
  input  logic                       rm_in,
  input  logic [SLW-1:0]             nxt_s,
  input  logic [SLW-1:0]             prv_c,
  input  logic                       prv_g,
  output logic [SLW-1:0]             cur_s,
  output logic                       rm_out,
  output logic [SLW-1:0]             c_s,
  output logic                       g_out
);

  // Slot layout: {valid, age, value}
  logic [SLW-1:0]             slot_r;
  logic [SLW-1:0]             slot_nxt;
  logic                       cur_valid;
  logic [AW-1:0]              cur_age;
  logic                       del;
  logic                       rm_le;
  logic                       c_valid;
  logic signed [SAMPLE_W-1:0] c_value;
  logic                       sel_new;
  logic [SLW-1:0]             src;

  assign cur_s     = slot_r;
  assign cur_valid = slot_r[SLW-1];
  assign cur_age   = slot_r[SLW-2 -: AW];

  // Oldest sample drops out when the window is full
  assign del    = ctl.full && cur_valid && (cur_age == oldest_age);
  assign rm_le  = rm_in | del;
  assign rm_out = rm_le;

  // Chain with the oldest removed: cells at or past it pull from the right
  assign c_s     = rm_le ? nxt_s : slot_r;
  assign c_valid = c_s[SLW-1];
  assign c_value = c_s[SAMPLE_W-1:0];

  // Insertion point: first compacted slot that is empty or larger
  assign g_out   = !c_valid || (c_value > new_sample);
  assign sel_new = g_out && !prv_g;
  assign src     = g_out ? prv_c : c_s;

  always_comb begin
    if (sel_new) begin
      slot_nxt = {1'b1, {AW{1'b0}}, new_sample};
    end else begin
      slot_nxt = {src[SLW-1], AW'(src[SLW-2 -: AW] + 1'b1), src[SAMPLE_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r[SLW-1] <= 1'b0;
    end else if (ctl.clr) begin
      slot_r[SLW-1] <= 1'b0;
    end else if (ctl.upd) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

/* sv/swmf_median.sv */
module swmf_median import swmf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int IW         = 4,
  parameter int HW         = 5
) (
  input  logic signed [SAMPLE_W-1:0] vals [MAX_WINDOW],
  input  logic [HW-1:0]              held,
  output logic signed [SAMPLE_W-1:0] median
);

  logic [HW-1:0]              half;
  logic [HW-1:0]              half_m1;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W:0]   sum;

  // Middle entries of the sorted chain
  assign half    = held >> 1;
  assign half_m1 = HW'(half - 1'b1);
  assign hi      = vals[half[IW-1:0]];
  assign lo      = vals[half_m1[IW-1:0]];

  // Even count: floor of half the exact sum, i.e. drop the sum's low bit
  assign sum    = (SAMPLE_W+1)'(lo) + (SAMPLE_W+1)'(hi);
  assign median = held[0] ? hi : sum[SAMPLE_W:1];

endmodule

/* sv/sliding_window_median_filter.sv */
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_stall    | swmf_in_t  {kind, sample}
// out_    | output    | out_valid / out_stall  | swmf_out_t {median, fill_count}
// cfg_    | input     | cfg_valid / cfg_ready  | window_size (5 bits)
//
// One item per cycle sustained while out_stall is low. The sorted chain
// inserts the new sample and drops the oldest one in the same update; the
// median is then picked from the chain into the output register once free.
// Reset is synchronous: the chain empties and window_size returns to 5.
// in_stall rises only while a computed result cannot move into a stalled
// output register. A clear transaction gives no result.
module sliding_window_median_filter import swmf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  swmf_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output swmf_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HW  = $clog2(MAX_WINDOW + 1);
  localparam int EW  = (HW > CFG_W) ? HW : CFG_W;
  localparam int SLW = 1 + IW + SAMPLE_W;

  logic [CFG_W-1:0]           size_r;
  logic [HW-1:0]              held_r;
  logic [HW-1:0]              held_nxt;
  logic                       pend_r;
  logic                       pend_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  swmf_out_t                  out_data_r;
  logic [EW-1:0]              size_ext;
  logic [EW-1:0]              eff_ext;
  logic [HW-1:0]              eff;
  logic [HW-1:0]              eff_m1;
  logic                       in_acc;
  logic                       out_free;
  logic                       load;
  swmf_ctl_t                  ctl;
  logic [SLW-1:0]             cur_s [MAX_WINDOW];
  logic [SLW-1:0]             c_s   [MAX_WINDOW];
  logic [MAX_WINDOW:0]        rm_v;
  logic [MAX_WINDOW-1:0]      g_v;
  logic [MAX_WINDOW-1:0]      valid_v;
  logic signed [SAMPLE_W-1:0] vals  [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] median;

  // Configuration register; the user must write it only while idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  // Effective window: zero acts as one, saturate at capacity
  assign size_ext = EW'(size_r);
  assign eff_ext  = (size_ext == '0) ? EW'(1) :
                    (size_ext > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : size_ext;
  assign eff      = eff_ext[HW-1:0];
  assign eff_m1   = HW'(eff - 1'b1);

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = pend_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign load     = pend_r && out_free;

  assign ctl.upd  = in_acc && (in_data.kind == KIND_SAMPLE);
  assign ctl.clr  = in_acc && (in_data.kind == KIND_CLEAR);
  assign ctl.full = (held_r >= eff);

  // Fill count
  always_comb begin
    held_nxt = held_r;
    if (ctl.clr) begin
      held_nxt = '0;
    end else if (ctl.upd) begin
      held_nxt = ctl.full ? eff : HW'(held_r + 1'b1);
    end
  end

  // Result pending and output register
  assign pend_nxt      = ctl.upd ? 1'b1 : (load ? 1'b0 : pend_r);
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.median     <= median;
      out_data_r.fill_count <= FILL_W'(held_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sorted chain of cells, ascending by value, each with an age tag
  assign rm_v[0] = 1'b0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [SLW-1:0] nxt_s;
    logic [SLW-1:0] prv_c;
    logic           prv_g;

    if (k == MAX_WINDOW - 1) begin : g_last
      assign nxt_s = '0;
    end else begin : g_mid
      assign nxt_s = cur_s[k+1];
    end

    if (k == 0) begin : g_first
      assign prv_c = '0;
      assign prv_g = 1'b0;
    end else begin : g_rest
      assign prv_c = c_s[k-1];
      assign prv_g = g_v[k-1];
    end

    swmf_cell #(
      .AW  (IW),
      .SLW (SLW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .oldest_age (eff_m1[IW-1:0]),
      .new_sample (in_data.sample),
      .rm_in      (rm_v[k]),
      .nxt_s      (nxt_s),
      .prv_c      (prv_c),
      .prv_g      (prv_g),
      .cur_s      (cur_s[k]),
      .rm_out     (rm_v[k+1]),
      .c_s        (c_s[k]),
      .g_out      (g_v[k])
    );

    assign valid_v[k] = cur_s[k][SLW-1];
    assign vals[k]    = cur_s[k][SAMPLE_W-1:0];
  end

  // Median of the held samples
  swmf_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .IW         (IW),
    .HW         (HW)
  ) u_median (
    .vals   (vals),
    .held   (held_r),
    .median (median)
  );

  // Occupied cells match the fill count
  a_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == held_r)
    else $error("occupied cells differ from fill count");

  // Occupied cells form a prefix of the chain
  a_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, valid_v} + {{MAX_WINDOW{1'b0}}, 1'b1}))
    else $error("gap in sorted chain");

  // A full window always finds its oldest sample
  a_oldest : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd && ctl.full |-> rm_v[MAX_WINDOW])
    else $error("oldest sample not found");

  // Insertion never pushes a live sample off the end
  a_fit : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.upd |-> g_v[MAX_WINDOW-1] && !c_s[MAX_WINDOW-1][SLW-1])
    else $error("sample lost at end of chain");

  // A clear transaction empties the window
  a_clear : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> held_r == '0 && !pend_r)
    else $error("clear left samples counted");

endmodule
